>>> sv/npc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color mapper.
// ----------------------------------------------------------------------------
package npc_pkg;

    // channel and distance widths (sum of three 8-bit differences fits 10 bits)
    localparam int CH_W   = 8;
    localparam int DIST_W = 10;
    localparam int IDX_W  = 4;
    localparam int SIZE_W = 5;

    // request modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_MAP  = 1'b1;

    // one color, red in the top byte
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // compare status handed back to the sequencer
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              take;
    } t_cmp;

endpackage

>>> sv/npc_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_dist
// Shared distance and compare unit: sum of absolute channel differences
// between pixel and one palette entry, and strictly-closer decision.
// ----------------------------------------------------------------------------
module npc_dist (
    input  npc_pkg::t_rgb              i_pixel,
    input  npc_pkg::t_rgb              i_entry,
    input  logic [npc_pkg::DIST_W-1:0] i_best_dist,
    input  logic                       i_first,
    output npc_pkg::t_cmp              o_cmp
);
    import npc_pkg::*;

    logic [CH_W-1:0]   d_r;
    logic [CH_W-1:0]   d_g;
    logic [CH_W-1:0]   d_b;
    logic [DIST_W-1:0] sum;

    // absolute differences per channel
    assign d_r = (i_entry.red > i_pixel.red) ? (i_entry.red - i_pixel.red)
                                             : (i_pixel.red - i_entry.red);
    assign d_g = (i_entry.green > i_pixel.green) ? (i_entry.green - i_pixel.green)
                                                 : (i_pixel.green - i_entry.green);
    assign d_b = (i_entry.blue > i_pixel.blue) ? (i_entry.blue - i_pixel.blue)
                                               : (i_pixel.blue - i_entry.blue);

    assign sum = DIST_W'(d_r) + DIST_W'(d_g) + DIST_W'(d_b);

    // first entry always wins; later ones only when strictly closer
    assign o_cmp.distance = sum;
    assign o_cmp.take     = i_first | (sum < i_best_dist);

endmodule

>>> sv/nearest_palette_color_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_map_core
// Maps RGB pixels to the closest color of a stored palette (L1 distance).
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start while busy is low. A load request (i_mode = 0)
//   writes i_red/i_green/i_blue to palette entry i_entry_index, gives no
//   result and leaves busy low; entries at or beyond PALETTE_DEPTH are
//   dropped. A map request (i_mode = 1) scans entries 0 .. N-1, where N is
//   the palette size clamped to 1 .. PALETTE_DEPTH, one entry per cycle
//   through a single distance/compare unit fed from the palette RAM.
//   Busy stays high through one RAM read setup state plus the N compares;
//   the result shows on o_out_* with o_valid for exactly one cycle right
//   after, and a new request can be taken in that same cycle. Ties go to the
//   lowest entry. The receiver cannot stall; results must be taken when shown.
//   The palette size register is written by i_cfg_we/i_cfg_wdata; the user
//   must write it only while idle, as the block does not enforce this.
//   Reset clears the sequencer and sets palette size to 1; palette RAM
//   contents are undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_palette_color_map_core #(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_mode,
    input  logic [npc_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [npc_pkg::CH_W-1:0]   i_red,
    input  logic [npc_pkg::CH_W-1:0]   i_green,
    input  logic [npc_pkg::CH_W-1:0]   i_blue,
    input  logic                       i_frame_end,
    input  logic                       i_cfg_we,
    input  logic [npc_pkg::SIZE_W-1:0] i_cfg_wdata,
    output logic                       o_valid,
    output logic [npc_pkg::CH_W-1:0]   o_out_red,
    output logic [npc_pkg::CH_W-1:0]   o_out_green,
    output logic [npc_pkg::CH_W-1:0]   o_out_blue,
    output logic                       o_last_pixel
);
    import npc_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;

    logic [1:0]        r_state;
    logic [SIZE_W-1:0] r_palette_size;
    t_rgb              r_mem [PALETTE_DEPTH];
    t_rgb              r_rd_data;
    logic [AW-1:0]     r_rd_addr;
    logic [AW-1:0]     r_cmp_idx;
    logic [AW-1:0]     r_last_idx;
    t_rgb              r_pixel;
    logic              r_frame_end;
    t_rgb              r_best;
    logic [DIST_W-1:0] r_best_dist;
    logic              r_valid;
    t_rgb              r_out;
    logic              r_out_last;

    logic              accept;
    logic              do_load;
    logic              do_map;
    logic [AW-1:0]     last_idx;
    t_rgb              n_best;
    t_cmp              cmp;

    assign accept  = start & ~busy;
    assign do_load = accept & (i_mode == MODE_LOAD) &
                     (32'(i_entry_index) < PALETTE_DEPTH);
    assign do_map  = accept & (i_mode == MODE_MAP);

    // last entry to compare: palette size clamped to 1 .. PALETTE_DEPTH, minus one
    always_comb begin
        if (r_palette_size == '0) begin
            last_idx = '0;
        end else if (32'(r_palette_size) > PALETTE_DEPTH) begin
            last_idx = AW'(PALETTE_DEPTH - 1);
        end else begin
            last_idx = AW'(r_palette_size - SIZE_W'(1));
        end
    end

    // palette size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_size <= SIZE_W'(1);
        end else if (i_cfg_we) begin
            r_palette_size <= i_cfg_wdata;
        end
    end

    // palette RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_mem[AW'(i_entry_index)] <= '{red: i_red, green: i_green, blue: i_blue};
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    // shared distance/compare unit
    npc_dist u_dist (
        .i_pixel     (r_pixel),
        .i_entry     (r_rd_data),
        .i_best_dist (r_best_dist),
        .i_first     (r_cmp_idx == '0),
        .o_cmp       (cmp)
    );

    assign n_best = cmp.take ? r_rd_data : r_best;

    // scan sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (do_map) begin
                        r_state <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (r_cmp_idx == r_last_idx) begin
                        r_state <= ST_IDLE;
                        r_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        if (do_map) begin
            r_pixel     <= '{red: i_red, green: i_green, blue: i_blue};
            r_frame_end <= i_frame_end;
            r_last_idx  <= last_idx;
            r_rd_addr   <= '0;
            r_cmp_idx   <= '0;
        end else if (r_state == ST_FETCH) begin
            r_rd_addr <= r_rd_addr + AW'(1);
        end else if (r_state == ST_CMP) begin
            r_rd_addr <= r_rd_addr + AW'(1);
            r_cmp_idx <= r_cmp_idx + AW'(1);
            if (cmp.take) begin
                r_best      <= r_rd_data;
                r_best_dist <= cmp.distance;
            end
            if (r_cmp_idx == r_last_idx) begin
                r_out      <= n_best;
                r_out_last <= r_frame_end;
            end
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_out_red    = r_out.red;
    assign o_out_green  = r_out.green;
    assign o_out_blue   = r_out.blue;
    assign o_last_pixel = r_out_last;

endmodule
